@@ design/cvs_pkg.sv @@
// Shared types, constants and tables for the composite video scanline sequencer.
`default_nettype none

package cvs_pkg;

  // Default sizes, handed to the top level's parameters.
  localparam int unsigned TOTAL_LINE_COUNT_DEF = 312;
  localparam int unsigned MAX_LINE_BYTES_DEF   = 32;
  localparam int unsigned STORE_DEPTH_DEF      = 4096;

  // Field widths fixed by the interface.
  localparam int unsigned LINE_W      = 9;
  localparam int unsigned FRAME_W     = 32;
  localparam int unsigned ADDR_IN_W   = 12;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 9;
  // Byte count covers the largest line length of 63.
  localparam int unsigned COUNT_W     = 7;
  // Row times bytes per line: 9 bits by 6 bits.
  localparam int unsigned BASE_W      = 15;
  // Glyph line times row stride plus code times four.
  localparam int unsigned FONT_SUM_W  = 13;

  // Queue and output buffer depths (powers of two).
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned OUT_DEPTH   = 4;

  // Vertical sync lines.
  localparam logic [LINE_W-1:0] LONG_SYNC_ON_LINE  = 9'd302;
  localparam logic [LINE_W-1:0] LONG_SYNC_OFF_LINE = 9'd310;

  // Text geometry.
  localparam logic [3:0]  ROW_SCANLINES   = 4'd14;
  localparam int unsigned FONT_ROW_STRIDE = 128 * 4;
  localparam int unsigned FONT_ROW_SHIFT  = $clog2(FONT_ROW_STRIDE);
  localparam int unsigned GLYPH_BYTES     = 4;

  // Input operation codes.
  localparam logic [1:0] OP_LINE_TICK = 2'd0;
  localparam logic [1:0] OP_FRAME_WR  = 2'd1;
  localparam logic [1:0] OP_FONT_WR   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_VIDEO_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_TOP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_LINE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_BYTES  = 2'd3;

  // Video modes; the spare code behaves as text.
  localparam logic [1:0] MODE_GFX4     = 2'd0;
  localparam logic [1:0] MODE_GFX2     = 2'd1;
  localparam logic [1:0] MODE_TEXT     = 2'd2;
  localparam logic [1:0] MODE_TEXT_ALT = 2'd3;

  // Register values after reset.
  localparam logic [1:0]        MODE_RESET       = MODE_GFX4;
  localparam logic [LINE_W-1:0] BLANK_TOP_RESET  = 9'd29;
  localparam logic [LINE_W-1:0] ACTIVE_RESET     = 9'd256;
  localparam logic [5:0]        LINE_BYTES_RESET = 6'd16;

  // Glyph line for each scanline of a text row.
  localparam logic [2:0] GLYPH_LINE_MAP [16] = '{
    3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4,
    3'd5, 3'd5, 3'd6, 3'd6, 3'd7, 3'd7, 3'd0, 3'd0
  };

  typedef enum logic [1:0] {
    CMD_LINE,
    CMD_FRAME_WR,
    CMD_FONT_WR
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]           op;
    logic [ADDR_IN_W-1:0] address;
    logic [7:0]           write_data;
  } in_t;

  typedef struct packed {
    logic [7:0]         pixels;
    logic               pixels_valid;
    logic               last;
    logic [LINE_W-1:0]  line_number;
    logic [FRAME_W-1:0] frame_count;
    logic               long_sync;
  } out_t;

  // One classified job passed from the front end to the back end.
  typedef struct packed {
    cmd_kind_e            kind;
    logic [ADDR_IN_W-1:0] address;
    logic [7:0]           write_data;
    logic                 blank;
    logic                 text;
    logic [BASE_W-1:0]    base;
    logic [2:0]           glyph;
    logic [COUNT_W-1:0]   count;
    logic [LINE_W-1:0]    line_number;
    logic [FRAME_W-1:0]   frame_count;
    logic                 long_sync;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/cvs_front.sv @@
// Front end: configuration registers, raster counters and job classification.
`default_nettype none

module cvs_front import cvs_pkg::*; #(
  parameter int unsigned TOTAL_LINE_COUNT = TOTAL_LINE_COUNT_DEF,
  parameter int unsigned MAX_LINE_BYTES   = MAX_LINE_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  in_t                    in_data_i,
  output logic                   in_stall_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   push_o,
  output cmd_t                   push_cmd_o,
  input  logic                   full_i
);

  logic [1:0]         mode_q, mode_d;
  logic [LINE_W-1:0]  blank_q, blank_d;
  logic [LINE_W-1:0]  active_q, active_d;
  logic [5:0]         bpl_q, bpl_d;

  logic [LINE_W-1:0]  line_q, line_d;
  logic [FRAME_W-1:0] frames_q, frames_d;
  logic               flag_q, flag_d;
  logic [4:0]         row_q, row_d;
  logic [3:0]         scan_q, scan_d;

  logic               accept;
  logic               tick;
  logic [LINE_W:0]    line_end;
  logic               in_active;
  logic [LINE_W-1:0]  act;
  logic               text_mode;
  logic               first_row;
  logic [4:0]         row_eff;
  logic [3:0]         scan_eff;
  logic [3:0]         scan_next;
  logic [LINE_W-1:0]  gfx_row;
  logic [LINE_W-1:0]  mul_a;
  logic [BASE_W-1:0]  product;
  logic [COUNT_W-1:0] count;
  logic [LINE_W:0]    line_next;

  assign accept      = in_valid_i && !full_i;
  assign tick        = accept && (in_data_i.op == OP_LINE_TICK);
  assign in_stall_o  = full_i;
  assign cfg_ready_o = 1'b1;

  // Where the current line sits in the raster.
  always_comb begin
    line_end  = {1'b0, blank_q} + {1'b0, active_q};
    in_active = (line_q >= blank_q) && ({1'b0, line_q} < line_end);
    act       = line_q - blank_q;
    text_mode = mode_q inside {MODE_TEXT, MODE_TEXT_ALT};
    first_row = (act == '0);
    row_eff   = first_row ? '0 : row_q;
    scan_eff  = first_row ? '0 : scan_q;
    gfx_row   = (mode_q == MODE_GFX4) ? (act >> 2) : (act >> 1);
    mul_a     = text_mode ? {4'b0, row_eff} : gfx_row;
    product   = BASE_W'(mul_a) * BASE_W'(bpl_q);
  end

  // Byte count, with zero taken as one and large values clipped.
  always_comb begin
    if (bpl_q == '0) begin
      count = COUNT_W'(1);
    end else if ({1'b0, bpl_q} > COUNT_W'(MAX_LINE_BYTES)) begin
      count = COUNT_W'(MAX_LINE_BYTES);
    end else begin
      count = {1'b0, bpl_q};
    end
  end

  // Configuration writes.
  always_comb begin
    mode_d   = mode_q;
    blank_d  = blank_q;
    active_d = active_q;
    bpl_d    = bpl_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VIDEO_MODE:  mode_d   = cfg_data_i[1:0];
        CFG_BLANK_TOP:   blank_d  = cfg_data_i;
        CFG_ACTIVE_LINE: active_d = cfg_data_i;
        CFG_LINE_BYTES:  bpl_d    = cfg_data_i[5:0];
        default:         mode_d   = mode_q;
      endcase
    end
  end

  // Line ticks step the line count, and row and scanline on active text lines.
  always_comb begin
    line_d    = line_q;
    frames_d  = frames_q;
    flag_d    = flag_q;
    row_d     = row_q;
    scan_d    = scan_q;
    scan_next = scan_eff + 4'd1;
    line_next = {1'b0, line_q} + (LINE_W+1)'(1);
    if (tick) begin
      if (in_active) begin
        if (text_mode) begin
          if (scan_next >= ROW_SCANLINES) begin
            scan_d = '0;
            row_d  = row_eff + 5'd1;
          end else begin
            scan_d = scan_next;
            row_d  = row_eff;
          end
        end
      end else if (line_q >= blank_q) begin
        if (line_q == LONG_SYNC_ON_LINE) begin
          flag_d = 1'b1;
        end else if (line_q >= LONG_SYNC_OFF_LINE) begin
          flag_d = 1'b0;
        end
      end
      if (line_next >= (LINE_W+1)'(TOTAL_LINE_COUNT)) begin
        line_d   = '0;
        frames_d = frames_q + FRAME_W'(1);
      end else begin
        line_d = line_next[LINE_W-1:0];
      end
    end
  end

  // Job handed to the queue.
  always_comb begin
    push_o = accept && (in_data_i.op inside {OP_LINE_TICK, OP_FRAME_WR, OP_FONT_WR});
    case (in_data_i.op)
      OP_FRAME_WR: push_cmd_o.kind = CMD_FRAME_WR;
      OP_FONT_WR:  push_cmd_o.kind = CMD_FONT_WR;
      default:     push_cmd_o.kind = CMD_LINE;
    endcase
    push_cmd_o.address     = in_data_i.address;
    push_cmd_o.write_data  = in_data_i.write_data;
    push_cmd_o.blank       = !in_active;
    push_cmd_o.text        = text_mode;
    push_cmd_o.base        = product;
    push_cmd_o.glyph       = GLYPH_LINE_MAP[scan_eff];
    push_cmd_o.count       = count;
    push_cmd_o.line_number = line_q;
    push_cmd_o.frame_count = frames_q;
    push_cmd_o.long_sync   = flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RESET;
      blank_q  <= BLANK_TOP_RESET;
      active_q <= ACTIVE_RESET;
      bpl_q    <= LINE_BYTES_RESET;
      line_q   <= '0;
      frames_q <= '0;
      flag_q   <= 1'b0;
      row_q    <= '0;
      scan_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      blank_q  <= blank_d;
      active_q <= active_d;
      bpl_q    <= bpl_d;
      line_q   <= line_d;
      frames_q <= frames_d;
      flag_q   <= flag_d;
      row_q    <= row_d;
      scan_q   <= scan_d;
    end
  end

endmodule

`default_nettype wire

@@ design/cvs_queue.sv @@
// Short job queue between the front end and the back end.
`default_nettype none

module cvs_queue import cvs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping; the depth is a power of two so pointers wrap.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + (PtrW+1)'(1);
      2'b01:   cnt_d = cnt_q - (PtrW+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ design/cvs_back.sv @@
// Back end: frame and font stores, byte read pipeline and output buffer.
`default_nettype none

module cvs_back import cvs_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  cmd_t job_i,
  output logic job_pop_o,
  output logic out_valid_o,
  output out_t out_data_o,
  input  logic out_stall_i
);

  localparam int unsigned AddrW      = $clog2(STORE_DEPTH);
  localparam int unsigned BankDepth  = STORE_DEPTH / GLYPH_BYTES;
  localparam int unsigned BankW      = $clog2(GLYPH_BYTES);
  localparam int unsigned OutPtrW    = $clog2(OUT_DEPTH);
  localparam int unsigned SumW       = (BASE_W >= AddrW) ? BASE_W + 1 : AddrW;

  // Per-byte tag carried alongside the store reads.
  typedef struct packed {
    logic               blank;
    logic               text;
    logic [2:0]         glyph;
    logic               last;
    logic [LINE_W-1:0]  line_number;
    logic [FRAME_W-1:0] frame_count;
    logic               long_sync;
  } tag_t;

  logic [7:0]         frame_mem [STORE_DEPTH];
  logic [7:0]         font_mem  [GLYPH_BYTES][BankDepth];

  logic [COUNT_W-1:0] idx_q, idx_d;
  logic               s1_valid_q, s2_valid_q;
  tag_t               s1_tag_q, s2_tag_q, issue_tag;
  logic [7:0]         frame_rd_q;
  logic [7:0]         s2_byte_q;
  logic [7:0]         font_rd_q [GLYPH_BYTES];

  out_t               fifo_q [OUT_DEPTH];
  logic [OutPtrW-1:0] fifo_wr_q, fifo_rd_q;
  logic [OutPtrW:0]   fifo_cnt_q, fifo_cnt_d;
  logic [OutPtrW+1:0] outstanding;

  logic               is_line;
  logic               issue;
  logic               last_byte;
  logic               frame_we;
  logic               font_we;
  logic [AddrW-1:0]   wr_addr;
  logic [SumW-1:0]    rd_sum;
  logic [AddrW-1:0]   rd_addr;
  logic [FONT_SUM_W-1:0] font_sum;
  logic [AddrW-1:0]   font_addr;
  logic [AddrW-BankW-1:0] font_bank_addr;
  logic [7:0]         glyph_pix;
  out_t               push_word;
  logic               fifo_pop;

  // Issue one byte a cycle while the output buffer has room for it.
  always_comb begin
    outstanding = (OutPtrW+2)'(fifo_cnt_q) + (OutPtrW+2)'(s1_valid_q)
                + (OutPtrW+2)'(s2_valid_q);
    is_line   = job_valid_i && (job_i.kind == CMD_LINE);
    issue     = is_line && (outstanding < (OutPtrW+2)'(OUT_DEPTH));
    last_byte = job_i.blank || ((idx_q + COUNT_W'(1)) == job_i.count);
    job_pop_o = (job_valid_i && (job_i.kind != CMD_LINE)) || (issue && last_byte);
    frame_we  = job_valid_i && (job_i.kind == CMD_FRAME_WR);
    font_we   = job_valid_i && (job_i.kind == CMD_FONT_WR);
    wr_addr   = AddrW'(job_i.address);
    rd_sum    = SumW'(job_i.base) + SumW'(idx_q);
    rd_addr   = AddrW'(rd_sum);
    idx_d     = idx_q;
    if (issue) begin
      idx_d = last_byte ? '0 : idx_q + COUNT_W'(1);
    end
    issue_tag.blank       = job_i.blank;
    issue_tag.text        = job_i.text;
    issue_tag.glyph       = job_i.glyph;
    issue_tag.last        = last_byte;
    issue_tag.line_number = job_i.line_number;
    issue_tag.frame_count = job_i.frame_count;
    issue_tag.long_sync   = job_i.long_sync;
  end

  // Frame store: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[wr_addr] <= job_i.write_data;
    end
    if (issue) begin
      frame_rd_q <= frame_mem[rd_addr];
    end
  end

  // Font address: the four glyph bytes sit one in each bank.
  always_comb begin
    font_sum = (FONT_SUM_W'(s1_tag_q.glyph) << FONT_ROW_SHIFT)
             + FONT_SUM_W'({frame_rd_q, 2'b00});
    font_addr      = AddrW'(font_sum);
    font_bank_addr = font_addr[AddrW-1:BankW];
  end

  // Font store, banked by the low address bits so a whole glyph is read at once.
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < GLYPH_BYTES; b++) begin
      if (font_we && (wr_addr[BankW-1:0] == BankW'(b))) begin
        font_mem[b][wr_addr[AddrW-1:BankW]] <= job_i.write_data;
      end
      if (s1_valid_q) begin
        font_rd_q[b] <= font_mem[b][font_bank_addr];
      end
    end
  end

  // Tags and the graphics byte follow the reads.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_tag_q <= issue_tag;
    end
    if (s1_valid_q) begin
      s2_tag_q  <= s1_tag_q;
      s2_byte_q <= frame_rd_q;
    end
  end

  // Each glyph byte gives bit 2 of its high nibble, then bit 2 of its low nibble.
  always_comb begin
    glyph_pix = '0;
    for (int k = 0; k < GLYPH_BYTES; k++) begin
      glyph_pix[7 - 2*k] = font_rd_q[k][6];
      glyph_pix[6 - 2*k] = font_rd_q[k][2];
    end
  end

  // Result word built from the last read stage.
  always_comb begin
    if (s2_tag_q.blank) begin
      push_word.pixels = '0;
    end else if (s2_tag_q.text) begin
      push_word.pixels = glyph_pix;
    end else begin
      push_word.pixels = s2_byte_q;
    end
    push_word.pixels_valid = !s2_tag_q.blank;
    push_word.last         = s2_tag_q.last;
    push_word.line_number  = s2_tag_q.line_number;
    push_word.frame_count  = s2_tag_q.frame_count;
    push_word.long_sync    = s2_tag_q.long_sync;
  end

  // Output buffer; room is reserved at issue so a push always fits.
  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_data_o  = fifo_q[fifo_rd_q];
  assign fifo_pop    = out_valid_o && !out_stall_i;

  always_comb begin
    case ({s2_valid_q, fifo_pop})
      2'b10:   fifo_cnt_d = fifo_cnt_q + (OutPtrW+1)'(1);
      2'b01:   fifo_cnt_d = fifo_cnt_q - (OutPtrW+1)'(1);
      default: fifo_cnt_d = fifo_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      fifo_q[fifo_wr_q] <= push_word;
    end
  end

  // Control state of the pipeline and the buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      fifo_wr_q  <= '0;
      fifo_rd_q  <= '0;
      fifo_cnt_q <= '0;
    end else begin
      idx_q      <= idx_d;
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
      fifo_cnt_q <= fifo_cnt_d;
      if (s2_valid_q) begin
        fifo_wr_q <= fifo_wr_q + OutPtrW'(1);
      end
      if (fifo_pop) begin
        fifo_rd_q <= fifo_rd_q + OutPtrW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/composite_video_scanout.sv @@
// Top level of the composite video scanline sequencer.
//
// Input channel: in_valid_i / in_stall_o carry one word of op, address and
// write_data. A line tick produces the results for one scanline; a frame or
// font store write updates the store and produces no result; op 3 is dropped.
// Output channel: out_valid_o / out_stall_i carry one result word; the last
// word of a line has last set. A blank line gives a single word.
// Configuration: cfg_valid_i / cfg_ready_o write one register, selected by
// cfg_index_i; the user must only write it while the block is idle (unenforced).
// An active line streams one word per cycle while the output buffer has room,
// one word per byte of the line (bytes_per_line, with zero taken as one and
// large values clipped).
// The pace is set by the single read port of the frame store; the font store
// is split into four banks so that a whole glyph is read at once.
// Reset clears the raster counters and restores the register defaults; the
// stores are not cleared and must be loaded before they are displayed.
// When the receiver stalls, the four-word output buffer fills, the back end
// holds, and once the job queue is full in_stall_o rises.
`default_nettype none

module composite_video_scanout import cvs_pkg::*; #(
  parameter int unsigned TOTAL_LINE_COUNT = TOTAL_LINE_COUNT_DEF,
  parameter int unsigned MAX_LINE_BYTES   = MAX_LINE_BYTES_DEF,
  parameter int unsigned STORE_DEPTH      = STORE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  in_t                    in_data_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output out_t                   out_data_o,
  input  logic                   out_stall_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic job_valid;
  cmd_t job;
  logic job_pop;

  // Classification and raster counting.
  cvs_front #(
    .TOTAL_LINE_COUNT (TOTAL_LINE_COUNT),
    .MAX_LINE_BYTES   (MAX_LINE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .full_i      (queue_full)
  );

  // Job queue.
  cvs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (queue_full),
    .pop_i      (job_pop),
    .valid_o    (job_valid),
    .head_o     (job)
  );

  // Store access and result delivery.
  cvs_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

@@ design/cvs_checker.sv @@
// Port-level checks of the scanline sequencer, bound to its top level.
`default_nettype none

module cvs_checker import cvs_pkg::*; #(
  parameter int unsigned TOTAL_LINE_COUNT = TOTAL_LINE_COUNT_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input out_t out_data_o,
  input logic out_stall_i
);

  // A stalled result word stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // A blank line is a single dark word that closes the line.
  a_blank_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.pixels_valid |->
      out_data_o.last && (out_data_o.pixels == 8'd0))
    else $error("blank line word malformed");

  // Reported line numbers stay within the frame.
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ({1'b0, out_data_o.line_number} < (LINE_W+1)'(TOTAL_LINE_COUNT)))
    else $error("line number outside the frame");

  // Nothing is offered straight out of reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result offered out of reset");

endmodule

bind composite_video_scanout cvs_checker #(
  .TOTAL_LINE_COUNT (TOTAL_LINE_COUNT)
) u_cvs_checker (.*);

`default_nettype wire
